// File: rtl/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared constants, command codes and controller/datapath interface types
// for the randomized Prim maze carver.
// ----------------------------------------------------------------------------
package pmc_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic [1:0] KIND_START    = 2'd0;
  localparam logic [1:0] KIND_CARVED   = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;

  localparam logic [1:0] DIR_PX = 2'd0;
  localparam logic [1:0] DIR_PY = 2'd1;
  localparam logic [1:0] DIR_MX = 2'd2;
  localparam logic [1:0] DIR_MY = 2'd3;

  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_MOD_A_W   = 5'd2;
  localparam logic [4:0] OP_MOD_B_H   = 5'd3;
  localparam logic [4:0] OP_MOD_A_CNT = 5'd4;
  localparam logic [4:0] OP_MOD_B_N   = 5'd5;
  localparam logic [4:0] OP_TAKE_SX   = 5'd6;
  localparam logic [4:0] OP_TAKE_SY   = 5'd7;
  localparam logic [4:0] OP_TAKE_SLOT = 5'd8;
  localparam logic [4:0] OP_TAKE_K    = 5'd9;
  localparam logic [4:0] OP_CLR       = 5'd10;
  localparam logic [4:0] OP_START     = 5'd11;
  localparam logic [4:0] OP_NB_RD     = 5'd12;
  localparam logic [4:0] OP_CHK       = 5'd13;
  localparam logic [4:0] OP_ADD       = 5'd14;
  localparam logic [4:0] OP_LIST_RD   = 5'd15;
  localparam logic [4:0] OP_LIST_TAKE = 5'd16;
  localparam logic [4:0] OP_JOIN      = 5'd17;
  localparam logic [4:0] OP_LAST_RD   = 5'd18;
  localparam logic [4:0] OP_REMOVE    = 5'd19;
  localparam logic [4:0] OP_EMIT      = 5'd20;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] dir;
    logic [1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic count_zero;
    logic n_zero;
    logic clr_last;
    logic out_free;
    logic mode_step;
  } status_t;

endpackage

// File: rtl/pmc_divider.sv
// ----------------------------------------------------------------------------
// pmc_divider
// Bit-serial restoring modulo unit: 16-bit dividend, one bit per cycle.
// ----------------------------------------------------------------------------
module pmc_divider #(
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [15:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] rem
);

  logic [15:0]   num;
  logic [DW-1:0] dvs;
  logic [DW:0]   acc;
  logic [DW:0]   trial;
  logic [4:0]    cnt;

  assign trial = {acc[DW-1:0], num[15]};
  assign rem   = acc[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      num  <= dividend;
      dvs  <= divisor;
      acc  <= '0;
      cnt  <= 5'd16;
      busy <= 1'b1;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        acc <= trial - {1'b0, dvs};
      end else begin
        acc <= trial;
      end
      num <= {num[14:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/pmc_datapath.sv
// ----------------------------------------------------------------------------
// pmc_datapath
// Config registers, mark and frontier memories, cell registers, modulo unit
// and output register of the maze carver.
// ----------------------------------------------------------------------------
module pmc_datapath import pmc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_user,
  input  logic [31:0]          in_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,
  output logic [1:0]           m_tuser
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int DW0   = (CNTW > XW + 1) ? CNTW : XW + 1;
  localparam int DW    = (DW0 > YW + 1) ? DW0 : YW + 1;
  localparam logic [1:0] MARK_NONE   = 2'b00;
  localparam logic [1:0] MARK_JOINED = 2'b01;
  localparam logic [1:0] MARK_FRONT  = 2'b10;

  logic [CFG_W-1:0] grid_width, grid_height;
  logic [XW:0]      effw;
  logic [YW:0]      effh;
  logic             mode;
  logic [15:0]      pick_a, pick_b;
  logic [XW-1:0]    start_x, cur_x, last_x, nb_x;
  logic [YW-1:0]    start_y, cur_y, last_y, nb_y;
  logic             nb_ok;
  logic [CNTW-1:0]  count;
  logic [AW-1:0]    slot, clr_addr;
  logic [3:0]       dmask;
  logic [1:0]       toward;
  logic [1:0]       mark_q;
  logic [XW+YW-1:0] list_q;

  logic [1:0]       marks [CELLS];
  logic [XW+YW-1:0] flist [CELLS];

  logic          out_valid;
  logic [1:0]    out_kind, out_dir;
  logic [5:0]    out_x, out_y, out_ox, out_oy;

  logic          div_go, div_busy;
  logic [15:0]   dividend;
  logic [DW-1:0] divisor, div_rem;

  logic [XW:0]   nx_c;
  logic [YW:0]   ny_c;
  logic          nb_ok_c, in_low;
  logic [AW-1:0] nb_addr_c;
  logic [2:0]    n_c;
  logic [1:0]    sel_dir;
  logic [2:0]    seen;
  logic          add_ok;

  logic             mark_we;
  logic [AW-1:0]    mark_wa;
  logic [1:0]       mark_wd;
  logic             list_we, list_re;
  logic [AW-1:0]    list_wa, list_ra;
  logic [XW+YW-1:0] list_wd;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y);
    return AW'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

  always_comb begin
    if (grid_width == '0) begin
      effw = (XW+1)'(1);
    end else if (int'(grid_width) > MAX_WIDTH) begin
      effw = (XW+1)'(MAX_WIDTH);
    end else begin
      effw = (XW+1)'(grid_width);
    end
    if (grid_height == '0) begin
      effh = (YW+1)'(1);
    end else if (int'(grid_height) > MAX_HEIGHT) begin
      effh = (YW+1)'(MAX_HEIGHT);
    end else begin
      effh = (YW+1)'(grid_height);
    end
  end

  // neighbor of the current cell in direction cmd.dir
  always_comb begin
    nx_c   = {1'b0, cur_x};
    ny_c   = {1'b0, cur_y};
    in_low = 1'b1;
    case (cmd.dir)
      DIR_PX: nx_c = {1'b0, cur_x} + 1'b1;
      DIR_PY: ny_c = {1'b0, cur_y} + 1'b1;
      DIR_MX: begin
        in_low = (cur_x != '0);
        nx_c   = {1'b0, cur_x} - 1'b1;
      end
      DIR_MY: begin
        in_low = (cur_y != '0);
        ny_c   = {1'b0, cur_y} - 1'b1;
      end
      default: ;
    endcase
    nb_ok_c   = in_low && (nx_c < effw) && (ny_c < effh);
    nb_addr_c = cell_addr(nx_c[XW-1:0], ny_c[YW-1:0]);
  end

  assign n_c = 3'($countones(dmask));

  // k-th joined neighbor, k = pick_b mod n
  always_comb begin
    sel_dir = DIR_PX;
    seen    = '0;
    for (int i = 0; i < 4; i++) begin
      if (dmask[i]) begin
        if (seen == {1'b0, div_rem[1:0]}) begin
          sel_dir = 2'(i);
        end
        seen = seen + 1'b1;
      end
    end
  end

  always_comb begin
    div_go   = 1'b0;
    dividend = pick_a;
    divisor  = DW'(effw);
    case (cmd.op)
      OP_MOD_A_W: div_go = 1'b1;
      OP_MOD_B_H: begin
        div_go   = 1'b1;
        dividend = pick_b;
        divisor  = DW'(effh);
      end
      OP_MOD_A_CNT: begin
        div_go  = 1'b1;
        divisor = DW'(count);
      end
      OP_MOD_B_N: begin
        div_go   = 1'b1;
        dividend = pick_b;
        divisor  = DW'(n_c);
      end
      default: ;
    endcase
  end

  pmc_divider #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  assign add_ok = nb_ok && (mark_q == MARK_NONE) && (count < CNTW'(CELLS));

  always_comb begin
    mark_we = 1'b0;
    mark_wa = clr_addr;
    mark_wd = MARK_NONE;
    list_we = 1'b0;
    list_wa = count[AW-1:0];
    list_wd = {nb_y, nb_x};
    list_re = 1'b0;
    list_ra = slot;
    case (cmd.op)
      OP_CLR: mark_we = 1'b1;
      OP_START: begin
        mark_we = 1'b1;
        mark_wa = cell_addr(start_x, start_y);
        mark_wd = MARK_JOINED;
      end
      OP_ADD: begin
        mark_we = add_ok;
        mark_wa = cell_addr(nb_x, nb_y);
        mark_wd = MARK_FRONT;
        list_we = add_ok;
      end
      OP_JOIN: begin
        mark_we = 1'b1;
        mark_wa = cell_addr(cur_x, cur_y);
        mark_wd = MARK_JOINED;
      end
      OP_LIST_RD: list_re = 1'b1;
      OP_LAST_RD: begin
        list_re = 1'b1;
        list_ra = AW'(count - 1'b1);
      end
      OP_REMOVE: begin
        list_we = 1'b1;
        list_wa = slot;
        list_wd = list_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks[mark_wa] <= mark_wd;
    end
    if (cmd.op == OP_NB_RD) begin
      mark_q <= marks[nb_addr_c];
    end
    if (list_we) begin
      flist[list_wa] <= list_wd;
    end
    if (list_re) begin
      list_q <= flist[list_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
      count       <= '0;
      start_x     <= '0;
      start_y     <= '0;
      last_x      <= '0;
      last_y      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end
      if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          mode     <= in_user;
          pick_a   <= in_data[15:0];
          pick_b   <= in_data[31:16];
          clr_addr <= '0;
        end
        OP_TAKE_SX: start_x <= XW'(div_rem);
        OP_TAKE_SY: start_y <= YW'(div_rem);
        OP_CLR:     clr_addr <= clr_addr + 1'b1;
        OP_START: begin
          cur_x  <= start_x;
          cur_y  <= start_y;
          last_x <= start_x;
          last_y <= start_y;
          count  <= '0;
          toward <= DIR_PX;
        end
        OP_NB_RD: begin
          nb_x  <= nx_c[XW-1:0];
          nb_y  <= ny_c[YW-1:0];
          nb_ok <= nb_ok_c;
        end
        OP_ADD: begin
          if (add_ok) begin
            count <= count + 1'b1;
          end
        end
        OP_TAKE_SLOT: slot <= AW'(div_rem);
        OP_LIST_TAKE: begin
          {cur_y, cur_x} <= list_q;
          dmask          <= '0;
        end
        OP_CHK: begin
          if (nb_ok && mark_q[0]) begin
            dmask[cmd.dir] <= 1'b1;
          end
        end
        OP_TAKE_K: toward <= sel_dir;
        OP_JOIN: begin
          last_x <= cur_x;
          last_y <= cur_y;
        end
        OP_REMOVE: count <= count - 1'b1;
        OP_EMIT: begin
          out_valid <= 1'b1;
          out_kind  <= cmd.kind;
          out_ox    <= 6'(start_x);
          out_oy    <= 6'(start_y);
          if (cmd.kind == KIND_FINISHED) begin
            out_x <= 6'(last_x);
            out_y <= 6'(last_y);
          end else begin
            out_x <= 6'(cur_x);
            out_y <= 6'(cur_y);
          end
          out_dir <= (cmd.kind == KIND_CARVED) ? toward : DIR_PX;
        end
        default: ;
      endcase
    end
  end

  assign status.div_busy   = div_busy;
  assign status.count_zero = (count == '0);
  assign status.n_zero     = (dmask == '0);
  assign status.clr_last   = (clr_addr == AW'(CELLS - 1));
  assign status.out_free   = !out_valid || m_tready;
  assign status.mode_step  = (mode == MODE_STEP);

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'd0, out_oy, out_ox, out_dir, out_y, out_x};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(CELLS)) else $error("frontier count above cell count");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |=> out_valid) else $error("emitted beat not presented");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_go |-> !div_busy) else $error("modulo started while busy");
  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_REMOVE |-> count != '0) else $error("removal from empty frontier");
`endif

endmodule

// File: rtl/pmc_ctrl.sv
// ----------------------------------------------------------------------------
// pmc_ctrl
// Sequencer for start, carve and finish items; drives datapath commands.
// ----------------------------------------------------------------------------
module pmc_ctrl import pmc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  logic    s_tuser,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_SX_GO     = 5'd1;
  localparam logic [4:0] ST_SX_WAIT   = 5'd2;
  localparam logic [4:0] ST_SY_GO     = 5'd3;
  localparam logic [4:0] ST_SY_WAIT   = 5'd4;
  localparam logic [4:0] ST_CLR       = 5'd5;
  localparam logic [4:0] ST_START     = 5'd6;
  localparam logic [4:0] ST_ADD_RD    = 5'd7;
  localparam logic [4:0] ST_ADD_WR    = 5'd8;
  localparam logic [4:0] ST_SLOT_GO   = 5'd9;
  localparam logic [4:0] ST_SLOT_WAIT = 5'd10;
  localparam logic [4:0] ST_LIST_RD   = 5'd11;
  localparam logic [4:0] ST_LIST_TAKE = 5'd12;
  localparam logic [4:0] ST_CHK_RD    = 5'd13;
  localparam logic [4:0] ST_CHK       = 5'd14;
  localparam logic [4:0] ST_CHK_END   = 5'd15;
  localparam logic [4:0] ST_K_GO      = 5'd16;
  localparam logic [4:0] ST_K_WAIT    = 5'd17;
  localparam logic [4:0] ST_JOIN      = 5'd18;
  localparam logic [4:0] ST_REM_RD    = 5'd19;
  localparam logic [4:0] ST_REM_WR    = 5'd20;
  localparam logic [4:0] ST_EMIT      = 5'd21;
  localparam logic [4:0] ST_FIN       = 5'd22;

  logic [4:0] state, state_next;
  logic [1:0] dir, dir_next;

  always_comb begin
    state_next = state;
    dir_next   = dir;
    cmd.op     = OP_NONE;
    cmd.dir    = dir;
    cmd.kind   = KIND_START;
    s_tready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op = OP_LOAD;
          if (s_tuser == MODE_START) begin
            state_next = ST_SX_GO;
          end else if (status.count_zero) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_SLOT_GO;
          end
        end
      end
      ST_SX_GO: begin
        cmd.op     = OP_MOD_A_W;
        state_next = ST_SX_WAIT;
      end
      ST_SX_WAIT: begin
        if (!status.div_busy) begin
          cmd.op     = OP_TAKE_SX;
          state_next = ST_SY_GO;
        end
      end
      ST_SY_GO: begin
        cmd.op     = OP_MOD_B_H;
        state_next = ST_SY_WAIT;
      end
      ST_SY_WAIT: begin
        if (!status.div_busy) begin
          cmd.op     = OP_TAKE_SY;
          state_next = ST_CLR;
        end
      end
      ST_CLR: begin
        cmd.op = OP_CLR;
        if (status.clr_last) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.op     = OP_START;
        dir_next   = DIR_PX;
        state_next = ST_ADD_RD;
      end
      ST_ADD_RD: begin
        cmd.op     = OP_NB_RD;
        state_next = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd.op = OP_ADD;
        if (dir == DIR_MY) begin
          state_next = status.mode_step ? ST_REM_RD : ST_EMIT;
        end else begin
          dir_next   = dir + 1'b1;
          state_next = ST_ADD_RD;
        end
      end
      ST_SLOT_GO: begin
        cmd.op     = OP_MOD_A_CNT;
        state_next = ST_SLOT_WAIT;
      end
      ST_SLOT_WAIT: begin
        if (!status.div_busy) begin
          cmd.op     = OP_TAKE_SLOT;
          state_next = ST_LIST_RD;
        end
      end
      ST_LIST_RD: begin
        cmd.op     = OP_LIST_RD;
        state_next = ST_LIST_TAKE;
      end
      ST_LIST_TAKE: begin
        cmd.op     = OP_LIST_TAKE;
        dir_next   = DIR_PX;
        state_next = ST_CHK_RD;
      end
      ST_CHK_RD: begin
        cmd.op     = OP_NB_RD;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        cmd.op = OP_CHK;
        if (dir == DIR_MY) begin
          state_next = ST_CHK_END;
        end else begin
          dir_next   = dir + 1'b1;
          state_next = ST_CHK_RD;
        end
      end
      ST_CHK_END: state_next = status.n_zero ? ST_REM_RD : ST_K_GO;
      ST_K_GO: begin
        cmd.op     = OP_MOD_B_N;
        state_next = ST_K_WAIT;
      end
      ST_K_WAIT: begin
        if (!status.div_busy) begin
          cmd.op     = OP_TAKE_K;
          state_next = ST_JOIN;
        end
      end
      ST_JOIN: begin
        cmd.op     = OP_JOIN;
        dir_next   = DIR_PX;
        state_next = ST_ADD_RD;
      end
      ST_REM_RD: begin
        cmd.op     = OP_LAST_RD;
        state_next = ST_REM_WR;
      end
      ST_REM_WR: begin
        cmd.op     = OP_REMOVE;
        state_next = status.n_zero ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        cmd.kind = status.mode_step ? KIND_CARVED : KIND_START;
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      ST_FIN: begin
        cmd.kind = KIND_FINISHED;
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dir   <= DIR_PX;
    end else begin
      state <= state_next;
      dir   <= dir_next;
    end
  end

endmodule

// File: rtl/randomized_prim_maze_carver_unit.sv
// Carve beat: two bit-serial modulo passes plus the mark-memory reads and
//   writes of the neighbour checks and frontier adds; finish beat: no modulo pass.
// Start beat: two modulo passes for the start cell, then the mark memory being
//   swept one cell per cycle. One item in flight; output register decoupled.
// Reset: synchronous; frontier empty, start/last cell (0,0), grid 64 x 64.
// ----------------------------------------------------------------------------
// randomized_prim_maze_carver_unit
// Randomized Prim maze carver with externally supplied random draws.
// ----------------------------------------------------------------------------
module randomized_prim_maze_carver_unit import pmc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // pick_a, pick_b
  input  logic                 s_tuser,   // mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // cell_x, cell_y, toward, origin_x, origin_y
  output logic [1:0]           m_tuser,   // kind
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  pmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  pmc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_user   (s_tuser),
    .in_data   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
